// ===== src/rhc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Shared widths, payload types and the job record passed from front to back.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int COMP_BITS   = 8;
  localparam int HUE_BITS    = 16;
  localparam int HDIV_BITS   = COMP_BITS + 3;
  localparam int PIPE_DEPTH  = (HUE_BITS > COMP_BITS) ? HUE_BITS : COMP_BITS;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
    logic [COMP_BITS-1:0] alpha;
  } pix_in_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]  hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] brightness;
    logic [COMP_BITS-1:0] alpha_out;
  } pix_out_t;

  typedef struct packed {
    logic                 grey;
    logic [COMP_BITS-1:0] brightness;
    logic [COMP_BITS-1:0] alpha;
    logic [COMP_BITS-1:0] sat_rem;
    logic [COMP_BITS-1:0] sat_low;
    logic [COMP_BITS-1:0] sat_div;
    logic [HDIV_BITS-1:0] hue_rem;
    logic [HDIV_BITS-1:0] hue_div;
  } job_t;

endpackage

// ===== src/rhc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter front end
// Classifies each pixel by its largest component and queues a division job.
// ----------------------------------------------------------------------------
module rhc_front #(
  parameter int DEPTH = rhc_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rhc_pkg::pix_in_t pixel,
  output logic            full,
  input  logic            take,
  output logic            job_valid,
  output rhc_pkg::job_t   job
);

  localparam int C  = rhc_pkg::COMP_BITS;
  localparam int HW = rhc_pkg::HDIV_BITS;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rhc_pkg::job_t  mem [DEPTH];
  rhc_pkg::job_t  cls;
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;
  logic           do_push;
  logic           do_pop;

  logic [C-1:0]    mx;
  logic [C-1:0]    mn;
  logic [C-1:0]    d;
  logic [HW-1:0]   d_ext;
  logic [HW-1:0]   six_d;
  logic [2*C-1:0]  prod;

  always_comb begin
    mx = pixel.red;
    if (pixel.green > mx) mx = pixel.green;
    if (pixel.blue > mx) mx = pixel.blue;
    mn = pixel.red;
    if (pixel.green < mn) mn = pixel.green;
    if (pixel.blue < mn) mn = pixel.blue;
    d     = mx - mn;
    d_ext = {3'b000, d};
    six_d = (d_ext << 2) + (d_ext << 1);
    prod  = {d, {C{1'b0}}} - {{C{1'b0}}, d};

    cls.grey       = (d == '0);
    cls.brightness = mx;
    cls.alpha      = pixel.alpha;
    cls.sat_rem    = prod[2*C-1:C];
    cls.sat_low    = prod[C-1:0];
    cls.sat_div    = mx;
    cls.hue_div    = six_d;
    priority if (mx == pixel.red) begin
      if (pixel.green >= pixel.blue) begin
        cls.hue_rem = {3'b000, pixel.green - pixel.blue};
      end else begin
        cls.hue_rem = six_d - {3'b000, pixel.blue - pixel.green};
      end
    end else if (mx == pixel.green) begin
      cls.hue_rem = (d_ext << 1) + {3'b000, pixel.blue} - {3'b000, pixel.red};
    end else begin
      cls.hue_rem = (d_ext << 2) + {3'b000, pixel.red} - {3'b000, pixel.green};
    end
  end

  assign full      = (count == CW'(DEPTH));
  assign job_valid = (count != '0);
  assign job       = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = take && job_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/rhc_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter pipelined divider
// Restoring division, one quotient bit per stage, padded to a common depth.
// ----------------------------------------------------------------------------
module rhc_div #(
  parameter int W     = rhc_pkg::COMP_BITS,
  parameter int QBITS = rhc_pkg::COMP_BITS,
  parameter int DEPTH = rhc_pkg::PIPE_DEPTH
) (
  input  logic             clk,
  input  logic             en,
  input  logic [W-1:0]     rem_in,
  input  logic [QBITS-1:0] low_in,
  input  logic [W-1:0]     div_in,
  output logic [QBITS-1:0] quo
);

  logic [W-1:0]     rem_q [DEPTH];
  logic [QBITS-1:0] low_q [DEPTH];
  logic [W-1:0]     div_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_stage
    logic [W-1:0]     r_src;
    logic [QBITS-1:0] l_src;
    logic [W-1:0]     d_src;
    logic [W:0]       t;
    logic [W:0]       diff;
    logic             ge;
    logic [W-1:0]     r_nxt;
    logic [QBITS-1:0] l_nxt;

    if (i == 0) begin : g_first
      assign r_src = rem_in;
      assign l_src = low_in;
      assign d_src = div_in;
    end else begin : g_rest
      assign r_src = rem_q[i-1];
      assign l_src = low_q[i-1];
      assign d_src = div_q[i-1];
    end

    always_comb begin
      t    = {r_src, l_src[QBITS-1]};
      diff = t - {1'b0, d_src};
      ge   = (t >= {1'b0, d_src});
      if (i < QBITS) begin
        r_nxt = ge ? diff[W-1:0] : t[W-1:0];
        l_nxt = {l_src[QBITS-2:0], ge};
      end else begin
        r_nxt = r_src;
        l_nxt = l_src;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[i] <= r_nxt;
        low_q[i] <= l_nxt;
        div_q[i] <= d_src;
      end
    end
  end

  assign quo = low_q[DEPTH-1];

endmodule

// ===== src/rhc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter back end
// Runs the hue and saturation divisions and holds the finished result.
// ----------------------------------------------------------------------------
module rhc_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  rhc_pkg::job_t    job,
  output logic             take,
  output logic             empty,
  input  logic             pop,
  output rhc_pkg::pix_out_t hsv
);

  localparam int C  = rhc_pkg::COMP_BITS;
  localparam int H  = rhc_pkg::HUE_BITS;
  localparam int HW = rhc_pkg::HDIV_BITS;
  localparam int N  = rhc_pkg::PIPE_DEPTH;

  logic         vld    [N];
  logic         grey   [N];
  logic [C-1:0] bright [N];
  logic [C-1:0] alpha  [N];
  logic         en;
  logic [H-1:0] hue_q;
  logic [C-1:0] sat_q;

  assign en   = !vld[N-1] || pop;
  assign take = en;

  rhc_div #(.W(HW), .QBITS(H), .DEPTH(N)) u_hue_div (
    .clk    (clk),
    .en     (en),
    .rem_in (job.hue_rem),
    .low_in ('0),
    .div_in (job.hue_div),
    .quo    (hue_q)
  );

  rhc_div #(.W(C), .QBITS(C), .DEPTH(N)) u_sat_div (
    .clk    (clk),
    .en     (en),
    .rem_in (job.sat_rem),
    .low_in (job.sat_low),
    .div_in (job.sat_div),
    .quo    (sat_q)
  );

  for (genvar i = 0; i < N; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= (i == 0) ? job_valid : vld[(i == 0) ? 0 : i - 1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (i == 0) begin
          grey[i]   <= job.grey;
          bright[i] <= job.brightness;
          alpha[i]  <= job.alpha;
        end else begin
          grey[i]   <= grey[(i == 0) ? 0 : i - 1];
          bright[i] <= bright[(i == 0) ? 0 : i - 1];
          alpha[i]  <= alpha[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  assign empty          = !vld[N-1];
  assign hsv.hue        = grey[N-1] ? '0 : hue_q;
  assign hsv.saturation = grey[N-1] ? '0 : sat_q;
  assign hsv.brightness = bright[N-1];
  assign hsv.alpha_out  = alpha[N-1];

endmodule

// ===== src/rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// Path: a pushed pixel is written into the job queue, then passes through the divider
// stages of the back end, whose depth is set by the one-bit-per-stage hue divider.
// Throughput: one pixel per cycle while results are being popped.
// Reset clears the job queue and the pipeline valid bits; results are lost.
// ----------------------------------------------------------------------------
// RGB to HSV converter top level
// Queue-style pixel interface around the classifying front and dividing back.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_top #(
  parameter int QUEUE_DEPTH = rhc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rhc_pkg::pix_in_t  pixel,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output rhc_pkg::pix_out_t hsv
);

  logic          take;
  logic          job_valid;
  rhc_pkg::job_t job;

  rhc_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pixel     (pixel),
    .full      (full),
    .take      (take),
    .job_valid (job_valid),
    .job       (job)
  );

  rhc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .take      (take),
    .empty     (empty),
    .pop       (pop),
    .hsv       (hsv)
  );

endmodule

// ===== src/rhc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter port checker
// Watches the top level ports for reset, hold and result consistency.
// ----------------------------------------------------------------------------
module rhc_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input rhc_pkg::pix_out_t hsv
);

  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(hsv))
    else $error("waiting result changed");

  a_black: assert property (@(posedge clk) disable iff (rst)
    !empty && hsv.brightness == '0 |-> hsv.saturation == '0 && hsv.hue == '0)
    else $error("black pixel with non-zero hue or saturation");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    !empty && hsv.saturation == '0 |-> hsv.hue == '0)
    else $error("grey pixel with non-zero hue");

endmodule

bind rgb_to_hsv_converter_top rhc_checker u_rhc_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .hsv   (hsv)
);

// ===== sim/tb_rgb_to_hsv_converter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Pushes directed and random RGBA pixels through the queue-style interface,
// with random gaps on the push side and random stalls on the pop side, and
// compares every popped HSVA transaction field by field against a predictor.
// ----------------------------------------------------------------------------
module tb_rgb_to_hsv_converter_top;

  localparam int COMP_BITS = rhc_pkg::COMP_BITS;
  localparam int HUE_BITS  = rhc_pkg::HUE_BITS;
  localparam int COMP_FULL = (1 << COMP_BITS) - 1;

  logic              clk   = 1'b0;
  logic              rst   = 1'b1;
  logic              push  = 1'b0;
  rhc_pkg::pix_in_t  pixel = '0;
  logic              pop   = 1'b0;
  logic              full;
  logic              empty;
  rhc_pkg::pix_out_t hsv;

  rhc_pkg::pix_out_t expected_hsv[$];
  int                fail_count = 0;
  bit                tx_burst   = 1'b0;
  bit                rx_burst   = 1'b0;

  rgb_to_hsv_converter_top u_dut (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pixel (pixel),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .hsv   (hsv)
  );

  always #10 clk = ~clk;

  function automatic rhc_pkg::pix_out_t predict_hsv(input rhc_pkg::pix_in_t p);
    longint            r;
    longint            g;
    longint            b;
    longint            mx;
    longint            mn;
    longint            d;
    longint            pos;
    rhc_pkg::pix_out_t o;
    r  = p.red;
    g  = p.green;
    b  = p.blue;
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;
    o.saturation = (mx != 0) ? COMP_BITS'((d * COMP_FULL) / mx) : '0;
    o.hue        = '0;
    if (d != 0) begin
      if (mx == r) begin
        pos = (g >= b) ? (g - b) : (6 * d - (b - g));
      end else if (mx == g) begin
        pos = 2 * d + b - r;
      end else begin
        pos = 4 * d + r - g;
      end
      o.hue = HUE_BITS'((pos << HUE_BITS) / (6 * d));
    end
    o.brightness = COMP_BITS'(mx);
    o.alpha_out  = p.alpha;
    return o;
  endfunction

  function automatic rhc_pkg::pix_in_t make_pixel(input int r, input int g,
                                                  input int b, input int a);
    rhc_pkg::pix_in_t p;
    p.red   = COMP_BITS'(r);
    p.green = COMP_BITS'(g);
    p.blue  = COMP_BITS'(b);
    p.alpha = COMP_BITS'(a);
    return p;
  endfunction

  task automatic send_pixel(input rhc_pkg::pix_in_t p);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 12);
    repeat (gap) begin
      @(negedge clk);
      push <= 1'b0;
    end
    @(negedge clk);
    push  <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (full) @(posedge clk);
    expected_hsv = {expected_hsv, predict_hsv(p)};
  endtask

  task automatic release_push();
    @(negedge clk);
    push <= 1'b0;
  endtask

  task automatic check_hsv(input rhc_pkg::pix_out_t got);
    rhc_pkg::pix_out_t want;
    if (expected_hsv.size() == 0) begin
      if (fail_count < 10) $display("Unexpected transaction: hue=%0d sat=%0d val=%0d alpha=%0d",
                                    got.hue, got.saturation, got.brightness, got.alpha_out);
      fail_count++;
    end else begin
      want = expected_hsv.pop_front();
      if (got.hue !== want.hue || got.saturation !== want.saturation ||
          got.brightness !== want.brightness || got.alpha_out !== want.alpha_out) begin
        if (fail_count < 10) begin
          $display("Mismatch: expected hue=%0d sat=%0d val=%0d alpha=%0d",
                   want.hue, want.saturation, want.brightness, want.alpha_out);
          $display("          actual   hue=%0d sat=%0d val=%0d alpha=%0d",
                   got.hue, got.saturation, got.brightness, got.alpha_out);
        end
        fail_count++;
      end
    end
  endtask

  initial begin
    int gap;
    #1;
    wait (rst == 1'b0);
    forever begin
      gap = rx_burst ? 0 : $urandom_range(0, 12);
      repeat (gap) begin
        @(negedge clk);
        pop <= 1'b0;
      end
      @(negedge clk);
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      check_hsv(hsv);
    end
  end

  task automatic test_directed();
    send_pixel(make_pixel(0, 0, 0, 0));
    send_pixel(make_pixel(255, 255, 255, 255));
    send_pixel(make_pixel(128, 128, 128, 170));
    send_pixel(make_pixel(1, 1, 1, 85));
    send_pixel(make_pixel(255, 0, 0, 0));
    send_pixel(make_pixel(0, 255, 0, 255));
    send_pixel(make_pixel(0, 0, 255, 90));
    send_pixel(make_pixel(255, 0, 1, 1));
    send_pixel(make_pixel(200, 10, 190, 254));
    send_pixel(make_pixel(255, 255, 0, 15));
    send_pixel(make_pixel(0, 255, 255, 240));
    send_pixel(make_pixel(255, 0, 255, 60));
    send_pixel(make_pixel(1, 0, 0, 128));
    send_pixel(make_pixel(0, 1, 0, 127));
    send_pixel(make_pixel(0, 0, 1, 64));
    send_pixel(make_pixel(255, 254, 254, 32));
    send_pixel(make_pixel(10, 255, 0, 16));
    send_pixel(make_pixel(0, 100, 255, 8));
    send_pixel(make_pixel(255, 128, 0, 4));
    send_pixel(make_pixel(254, 255, 253, 2));
    send_pixel(make_pixel(85, 170, 255, 205));
    release_push();
  endtask

  task automatic test_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_burst = ($urandom_range(0, 3) == 0);
        rx_burst = ($urandom_range(0, 3) == 0);
      end
      send_pixel(rhc_pkg::pix_in_t'($urandom));
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
    release_push();
  endtask

  task automatic test_ties_and_near_grey(input int count);
    int m;
    int lo;
    int c[3];
    int pick;
    for (int i = 0; i < count; i++) begin
      m = $urandom_range(0, COMP_FULL);
      if ($urandom_range(0, 1) == 0) begin
        pick = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) c[k] = m;
        c[pick] = $urandom_range(0, m);
      end else begin
        lo = (m > 2) ? m - 2 : 0;
        for (int k = 0; k < 3; k++) c[k] = $urandom_range(lo, m);
      end
      send_pixel(make_pixel(c[0], c[1], c[2], $urandom_range(0, COMP_FULL)));
    end
    release_push();
  endtask

  task automatic test_back_to_back(input int count);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    for (int i = 0; i < count; i++) send_pixel(rhc_pkg::pix_in_t'($urandom));
    release_push();
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 12; i++) send_pixel(rhc_pkg::pix_in_t'($urandom));
    release_push();
    wait (expected_hsv.size() == 0);
    for (int i = 0; i < 12; i++) send_pixel(rhc_pkg::pix_in_t'($urandom));
    release_push();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_pixels(250);
    test_ties_and_near_grey(100);
    test_back_to_back(50);
    test_drain_pause();
    wait (expected_hsv.size() == 0);
    repeat (40) @(posedge clk);
    if (fail_count == 0 && expected_hsv.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
src/rhc_pkg.sv
src/rhc_front.sv
src/rhc_div.sv
src/rhc_back.sv
src/rgb_to_hsv_converter_top.sv
src/rhc_checker.sv
sim/tb_rgb_to_hsv_converter_top.sv
